### rtl/core/obci_pkg.sv
// ----------------------------------------------------------------------------
// obci_pkg
// Shared types and constants for the oriented box / circle intersect pipeline.
// ----------------------------------------------------------------------------
package obci_pkg;

   localparam int NUM_STAGES = 8;

   // pipeline stage indexes
   localparam int ST_DIFF   = 0;
   localparam int ST_MUL    = 1;
   localparam int ST_PROJ   = 2;
   localparam int ST_EXCESS = 3;
   localparam int ST_PART   = 4;
   localparam int ST_SQ     = 5;
   localparam int ST_SUM    = 6;
   localparam int ST_OUT    = 7;

   localparam int REQ_DATA_W = 288;
   localparam int RSP_DATA_W = 64;
   localparam int DIFF_W     = 33;
   localparam int PROD_W     = 49;
   localparam int PROJ_W     = 36;
   localparam int MAG_W      = 36;
   localparam int HALF_W     = 18;
   localparam int SQ_W       = 72;
   localparam int SUM_W      = 73;
   localparam int R2_W       = 62;
   localparam int DIST_W     = 63;

   // input beat, last member in the lowest bits
   typedef struct packed {
      logic [2:0]         pad;
      logic [30:0]        radius;
      logic signed [31:0] circle_y;
      logic signed [31:0] circle_x;
      logic [30:0]        half_extent_b;
      logic [30:0]        half_extent_a;
      logic signed [15:0] axis_b_y;
      logic signed [15:0] axis_b_x;
      logic signed [15:0] axis_a_y;
      logic signed [15:0] axis_a_x;
      logic signed [31:0] box_center_y;
      logic signed [31:0] box_center_x;
   } req_beat_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctrl_type;

endpackage

### rtl/core/obci_proj.sv
// ----------------------------------------------------------------------------
// obci_proj
// Center difference, projection onto both axes and excess beyond extents.
// ----------------------------------------------------------------------------
module obci_proj
   import obci_pkg::*;
(
   input  logic                clock,
   input  pipe_ctrl_type       ctrl,
   input  req_beat_type        beat,
   output logic [MAG_W-1:0]    mag_a,
   output logic [MAG_W-1:0]    mag_b
);

   // stage: difference
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [15:0]       aax_ff, aay_ff, abx_ff, aby_ff;
   logic [30:0]              ea0_ff, eb0_ff;

   assign dx_in = $signed({beat.circle_x[31], beat.circle_x})
                - $signed({beat.box_center_x[31], beat.box_center_x});
   assign dy_in = $signed({beat.circle_y[31], beat.circle_y})
                - $signed({beat.box_center_y[31], beat.box_center_y});

   always_ff @(posedge clock) begin
      if (ctrl.en[ST_DIFF]) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         aax_ff <= beat.axis_a_x;
         aay_ff <= beat.axis_a_y;
         abx_ff <= beat.axis_b_x;
         aby_ff <= beat.axis_b_y;
         ea0_ff <= beat.half_extent_a;
         eb0_ff <= beat.half_extent_b;
      end
   end

   // stage: products
   logic signed [PROD_W-1:0] pax_ff, pax_in, pay_ff, pay_in;
   logic signed [PROD_W-1:0] pbx_ff, pbx_in, pby_ff, pby_in;
   logic [30:0]              ea1_ff, eb1_ff;

   assign pax_in = dx_ff * aax_ff;
   assign pay_in = dy_ff * aay_ff;
   assign pbx_in = dx_ff * abx_ff;
   assign pby_in = dy_ff * aby_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en[ST_MUL]) begin
         pax_ff <= pax_in;
         pay_ff <= pay_in;
         pbx_ff <= pbx_in;
         pby_ff <= pby_in;
         ea1_ff <= ea0_ff;
         eb1_ff <= eb0_ff;
      end
   end

   // stage: projection, floor of Q20.30 to Q20.16
   logic signed [PROD_W:0]   sa, sb;
   logic signed [PROJ_W-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [30:0]              ea2_ff, eb2_ff;

   assign sa    = $signed({pax_ff[PROD_W-1], pax_ff}) + $signed({pay_ff[PROD_W-1], pay_ff});
   assign sb    = $signed({pbx_ff[PROD_W-1], pbx_ff}) + $signed({pby_ff[PROD_W-1], pby_ff});
   assign pa_in = sa[PROD_W:14];
   assign pb_in = sb[PROD_W:14];

   always_ff @(posedge clock) begin
      if (ctrl.en[ST_PROJ]) begin
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         ea2_ff <= ea1_ff;
         eb2_ff <= eb1_ff;
      end
   end

   // stage: excess beyond extent
   logic [MAG_W-1:0] ma_ff, ma_in, mb_ff, mb_in;

   function automatic logic [MAG_W-1:0] excess(input logic signed [PROJ_W-1:0] p,
                                               input logic [30:0] ext);
      logic signed [PROJ_W:0] pw, ew, over, under, neg;
      pw    = $signed({p[PROJ_W-1], p});
      ew    = $signed({6'd0, ext});
      over  = pw - ew;
      under = pw + ew;
      neg   = -under;
      if (!over[PROJ_W] && (over != '0))
         return over[MAG_W-1:0];
      else if (under[PROJ_W])
         return neg[MAG_W-1:0];
      else
         return '0;
   endfunction

   assign ma_in = excess(pa_ff, ea2_ff);
   assign mb_in = excess(pb_ff, eb2_ff);

   always_ff @(posedge clock) begin
      if (ctrl.en[ST_EXCESS]) begin
         ma_ff <= ma_in;
         mb_ff <= mb_in;
      end
   end

   assign mag_a = ma_ff;
   assign mag_b = mb_ff;

endmodule

### rtl/core/obci_square.sv
// ----------------------------------------------------------------------------
// obci_square
// Exact 36-bit square from three 18x18 partial products over two stages.
// ----------------------------------------------------------------------------
module obci_square
   import obci_pkg::*;
(
   input  logic             clock,
   input  pipe_ctrl_type    ctrl,
   input  logic [MAG_W-1:0] mag,
   output logic [SQ_W-1:0]  square
);

   logic [HALF_W-1:0]   mh, ml;
   logic [2*HALF_W-1:0] hh_ff, hh_in, hl_ff, hl_in, ll_ff, ll_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;

   assign mh    = mag[MAG_W-1:HALF_W];
   assign ml    = mag[HALF_W-1:0];
   assign hh_in = mh * mh;
   assign hl_in = mh * ml;
   assign ll_in = ml * ml;

   always_ff @(posedge clock) begin
      if (ctrl.en[ST_PART]) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
      end
   end

   // m^2 = hh<<36 + 2*hl<<18 + ll
   assign sq_in = {hh_ff, {(2*HALF_W){1'b0}}}
                + {{(SQ_W-2*HALF_W-HALF_W-1){1'b0}}, hl_ff, {(HALF_W+1){1'b0}}}
                + {{(SQ_W-2*HALF_W){1'b0}}, ll_ff};

   always_ff @(posedge clock) begin
      if (ctrl.en[ST_SQ])
         sq_ff <= sq_in;
   end

   assign square = sq_ff;

endmodule

### rtl/core/oriented_box_circle_intersect_top.sv
// An accepted req beat passes the diff, mul, proj, excess, part, sq, sum and
// out stages in order to its rsp beat. Throughput: one beat per cycle while
// rsp is not stalled; every stage has its own valid bit and advances when it
// is empty or its successor advances, so bubbles close up under back pressure.
// Reset (synchronous, active high) clears all stage valid bits.
// ----------------------------------------------------------------------------
// oriented_box_circle_intersect_top
// Oriented box versus circle test: flag and scaled squared distance.
// ----------------------------------------------------------------------------
module oriented_box_circle_intersect_top
   import obci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // box_center_x[31:0], box_center_y[63:32], axis_a_x[79:64], axis_a_y[95:80],
   // axis_b_x[111:96], axis_b_y[127:112], half_extent_a[158:128],
   // half_extent_b[189:159], circle_x[221:190], circle_y[253:222],
   // radius[284:254], zero[287:285]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // intersects[0], dist_sq[63:1]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   req_beat_type          beat;
   pipe_ctrl_type         ctrl;
   logic [NUM_STAGES-1:0] vld_ff, vld_in;

   assign beat = req_beat_type'(req_tdata);

   // stage enables, from the output back
   always_comb begin
      ctrl.en[ST_OUT] = !vld_ff[ST_OUT] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--)
         ctrl.en[k] = !vld_ff[k] || ctrl.en[k+1];
   end

   always_comb begin
      vld_in = vld_ff;
      if (ctrl.en[0])
         vld_in[0] = req_tvalid;
      for (int k = 1; k < NUM_STAGES; k++)
         if (ctrl.en[k])
            vld_in[k] = vld_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else
         vld_ff <= vld_in;
   end

   assign req_tready = ctrl.en[ST_DIFF];

   // radius squared, carried alongside
   logic [30:0]     r0_ff;
   logic [R2_W-1:0] r2_in;
   logic [R2_W-1:0] r2_ff [ST_MUL:ST_SUM];

   assign r2_in = r0_ff * r0_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en[ST_DIFF])
         r0_ff <= beat.radius;
      if (ctrl.en[ST_MUL])
         r2_ff[ST_MUL] <= r2_in;
      for (int k = ST_MUL + 1; k <= ST_SUM; k++)
         if (ctrl.en[k])
            r2_ff[k] <= r2_ff[k-1];
   end

   logic [MAG_W-1:0] mag_a, mag_b;
   logic [SQ_W-1:0]  sq_a, sq_b;

   obci_proj u_proj (
      .clock (clock),
      .ctrl  (ctrl),
      .beat  (beat),
      .mag_a (mag_a),
      .mag_b (mag_b)
   );

   obci_square u_sq_a (
      .clock  (clock),
      .ctrl   (ctrl),
      .mag    (mag_a),
      .square (sq_a)
   );

   obci_square u_sq_b (
      .clock  (clock),
      .ctrl   (ctrl),
      .mag    (mag_b),
      .square (sq_b)
   );

   // sum of squared excesses, Q41.32
   logic [SUM_W-1:0] sum_ff, sum_in;

   assign sum_in = {1'b0, sq_a} + {1'b0, sq_b};

   always_ff @(posedge clock) begin
      if (ctrl.en[ST_SUM])
         sum_ff <= sum_in;
   end

   // compare and scale; the scaled sum always fits the distance field, so no saturation is needed
   logic              hit_ff, hit_in;
   logic [DIST_W-1:0] dist_ff, dist_in;

   assign hit_in  = sum_ff <= {{(SUM_W-R2_W){1'b0}}, r2_ff[ST_SUM]};
   assign dist_in = {{(DIST_W-(SUM_W-16)){1'b0}}, sum_ff[SUM_W-1:16]};

   always_ff @(posedge clock) begin
      if (ctrl.en[ST_OUT]) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = {dist_ff, hit_ff};

endmodule

### rtl/core/obci_checker.sv
// ----------------------------------------------------------------------------
// obci_checker
// Port-level checks for the box / circle intersect block, bound to the top.
// ----------------------------------------------------------------------------
module obci_checker
   import obci_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // empty output stage never back-pressures the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

   // no rsp beat right out of reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("rsp beat right after reset");

   // sum of two 72-bit squares, scaled by 2^-16, fits in 57 bits
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:58] == '0)
      else $error("distance out of range");

   // a hit bounds the distance by radius squared
   a_hit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[63:47] == '0)
      else $error("hit with distance above radius squared");

endmodule

bind oriented_box_circle_intersect_top obci_checker u_obci_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
